// File: sv/izn_pkg.sv
// Shared widths, codes and types of the Izhikevich neuron update core.
`timescale 1ns / 1ps
`default_nettype none

package izn_pkg;

    localparam int IDX_W     = 10;   // neuron index field
    localparam int Q_W       = 32;   // signed fixed-point value
    localparam int CNT_W     = 10;   // refractory countdown
    localparam int CFG_IDX_W = 3;    // configuration register index
    localparam int CFG_W     = 32;   // widest configuration register

    // request: {drive_current, neuron_index} padded to whole bytes
    localparam int S_TDATA_W = ((IDX_W + Q_W + 7) / 8) * 8;
    // result: {potential, neuron_out} padded to whole bytes
    localparam int M_TDATA_W = ((IDX_W + Q_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 1;

    typedef logic signed [Q_W-1:0] q_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REFRACT_STEPS  = 3'd0,
        CFG_FIRE_THRESHOLD = 3'd1,
        CFG_RECOVERY_RATE  = 3'd2,
        CFG_RECOVERY_SENS  = 3'd3,
        CFG_RESET_POT      = 3'd4,
        CFG_RECOVERY_JUMP  = 3'd5,
        CFG_STEP_SCALE     = 3'd6,
        CFG_INPUT_GAIN     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             fired;
        q_t               potential;
    } result_t;

endpackage

`default_nettype wire

// File: sv/izhikevich_neuron_update_core.sv
// Top level: Izhikevich neuron update core, memory-based read-modify-write pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Each request names one neuron and carries its drive current; the core reads the neuron's
// potential, recovery variable and refractory countdown from one state memory (registered read),
// advances it one Euler step (or counts down, or fires), writes it back and returns one result
// per request, in request order. A new request is taken every cycle as long as it names a
// neuron that is not still in the read-modify-write path (memory read alongside the
// first of nine pipeline stages, each product formed in one stage and rounded in the next,
// write-back at the edge after the last stage); a request for such a neuron waits until that
// neuron has been written back. Results enter a 16-entry output queue from the last stage and
// can leave it on the following cycle; requests are taken as long as the queue can hold every
// request in flight, so a stalled result side does not stop the input until the queue is full.
// After reset the state memory is cleared one entry per cycle, with s_tready low;
// configuration writes are taken throughout. Neuron indices at or above NEURONS change
// nothing and return fired 0 and potential 0.
module izhikevich_neuron_update_core #(
    parameter int NEURONS   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [izn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [izn_pkg::CFG_W-1:0]        cfg_wdata,
    // request channel
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [izn_pkg::S_TDATA_W-1:0]    s_tdata,   // neuron_index, drive_current
    // result channel
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [izn_pkg::M_TDATA_W-1:0]         m_tdata,   // neuron_out, potential
    output logic [izn_pkg::M_TUSER_W-1:0]         m_tuser    // fired
);
    import izn_pkg::*;

    localparam int AW         = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int NSTG       = 9;
    localparam int FIFO_DEPTH = 16;
    localparam int FAW        = 4;

    // Fixed-point constants
    localparam logic signed [63:0] HALF     = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
    localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;
    localparam q_t                 Q_004    = q_t'(((64'd4 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [63:0] Q_140    = 64'sd140 <<< FRAC_BITS;

    // Register reset values (30 mV, 0.2, -65 mV, 8)
    localparam q_t TH_RST   = q_t'(64'sd30 <<< FRAC_BITS);
    localparam q_t B_RST    = q_t'(((64'd2 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam q_t C_RST    = q_t'(-(64'sd65 <<< FRAC_BITS));
    localparam q_t D_RST    = q_t'(64'sd8 <<< FRAC_BITS);

    typedef enum logic [1:0] {
        MODE_SKIP,   // index beyond the memory
        MODE_REFR,   // refractory countdown
        MODE_FIRE,   // spike and reset
        MODE_STEP    // Euler step
    } mode_t;

    typedef struct packed {
        q_t               v;
        q_t               u;
        logic [CNT_W-1:0] cnt;
    } nstate_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        mode_t              mode;
        q_t                 drive;
        q_t                 v;
        q_t                 u;
        logic [CNT_W-1:0]   cnt;
        q_t                 u_fire;
        logic signed [63:0] prod_vv;
        logic signed [63:0] prod_bv;
        logic signed [63:0] prod_gd;
        q_t                 sq;
        q_t                 bv;
        q_t                 gd;
        logic signed [63:0] prod_004;
        q_t                 diff;
        q_t                 a004;
        logic signed [63:0] prod_rd;
        q_t                 t;
        q_t                 ur;
        logic signed [63:0] prod_st;
        q_t                 u_new;
        q_t                 st;
        q_t                 vb;
    } pipe_t;

    function automatic logic signed [63:0] wide(input q_t x);
        return 64'(x);
    endfunction

    // Clamp an exact wide value to 32 bits
    function automatic q_t sat_wide(input logic signed [63:0] x);
        if (x > WIDE_MAX) begin
            return q_t'(WIDE_MAX[Q_W-1:0]);
        end else if (x < WIDE_MIN) begin
            return q_t'(WIDE_MIN[Q_W-1:0]);
        end
        return q_t'(x[Q_W-1:0]);
    endfunction

    // Round a full product to FRAC_BITS fraction bits (add half, floor), then clamp
    function automatic q_t round_q(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + HALF) >>> FRAC_BITS;
        return sat_wide(s);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] refract_steps_reg;
    q_t               fire_threshold_reg;
    q_t               recovery_rate_reg;
    q_t               recovery_sens_reg;
    q_t               reset_potential_reg;
    q_t               recovery_jump_reg;
    q_t               step_scale_reg;
    q_t               input_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refract_steps_reg   <= '0;
            fire_threshold_reg  <= TH_RST;
            recovery_rate_reg   <= '0;
            recovery_sens_reg   <= B_RST;
            reset_potential_reg <= C_RST;
            recovery_jump_reg   <= D_RST;
            step_scale_reg      <= '0;
            input_gain_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_REFRACT_STEPS:  refract_steps_reg   <= cfg_wdata[CNT_W-1:0];
                CFG_FIRE_THRESHOLD: fire_threshold_reg  <= q_t'(cfg_wdata);
                CFG_RECOVERY_RATE:  recovery_rate_reg   <= q_t'(cfg_wdata);
                CFG_RECOVERY_SENS:  recovery_sens_reg   <= q_t'(cfg_wdata);
                CFG_RESET_POT:      reset_potential_reg <= q_t'(cfg_wdata);
                CFG_RECOVERY_JUMP:  recovery_jump_reg   <= q_t'(cfg_wdata);
                CFG_STEP_SCALE:     step_scale_reg      <= q_t'(cfg_wdata);
                CFG_INPUT_GAIN:     input_gain_reg      <= q_t'(cfg_wdata);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request side: interlock against neurons still in flight
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] s_idx;
    q_t               s_drive;
    logic             s_in_range;
    logic             hazard;
    logic             accept;
    logic             deliver;

    pipe_t            pipe_reg [1:NSTG];
    pipe_t            pipe_next [1:NSTG];
    logic [NSTG:1]    valid_reg;

    logic             clearing_reg;
    logic [AW-1:0]    clr_addr_reg;
    logic [FAW:0]     credit_reg;

    assign s_idx      = s_tdata[IDX_W-1:0];
    assign s_drive    = q_t'(s_tdata[IDX_W +: Q_W]);
    assign s_in_range = 32'(s_idx) < 32'(NEURONS);

    // Hold a request whose neuron has not yet been written back
    always_comb begin
        hazard = 1'b0;
        for (int k = 1; k <= NSTG; k++) begin
            if (valid_reg[k] && (pipe_reg[k].idx == s_idx)) begin
                hazard = 1'b1;
            end
        end
    end

    assign s_tready = !clearing_reg && (credit_reg != (FAW + 1)'(FIFO_DEPTH)) && !hazard;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // State memory: read on acceptance, written back at the last stage
    // ------------------------------------------------------------------
    nstate_t       state_mem [NEURONS];
    nstate_t       rd_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    nstate_t       mem_wdata;
    nstate_t       wb;
    result_t       res;
    q_t            v_step;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            state_mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= state_mem[AW'(s_idx)];
    end

    // Clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            if (clr_addr_reg == AW'(NEURONS - 1)) begin
                clearing_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Arithmetic pipeline: each 32 by 32 product in one stage, its rounding in the next
    // ------------------------------------------------------------------
    always_comb begin
        // Stage 1: capture the request while the memory read is under way
        pipe_next[1]       = '0;
        pipe_next[1].idx   = s_idx;
        pipe_next[1].drive = s_drive;
        pipe_next[1].mode  = s_in_range ? MODE_STEP : MODE_SKIP;

        // Stage 2: pick up stored state, decide the case, start v*v, b*v, gain*I
        pipe_next[2]     = pipe_reg[1];
        pipe_next[2].v   = rd_reg.v;
        pipe_next[2].u   = rd_reg.u;
        pipe_next[2].cnt = rd_reg.cnt;
        if (pipe_reg[1].mode == MODE_SKIP) begin
            pipe_next[2].mode = MODE_SKIP;
        end else if (rd_reg.cnt != '0) begin
            pipe_next[2].mode = MODE_REFR;
        end else if (rd_reg.v >= fire_threshold_reg) begin
            pipe_next[2].mode = MODE_FIRE;
        end else begin
            pipe_next[2].mode = MODE_STEP;
        end
        pipe_next[2].prod_vv = rd_reg.v * rd_reg.v;
        pipe_next[2].prod_bv = recovery_sens_reg * rd_reg.v;
        pipe_next[2].prod_gd = input_gain_reg * pipe_reg[1].drive;
        pipe_next[2].u_fire  = sat_wide(wide(rd_reg.u) + wide(recovery_jump_reg));

        // Stage 3: round the first products
        pipe_next[3]    = pipe_reg[2];
        pipe_next[3].sq = round_q(pipe_reg[2].prod_vv);
        pipe_next[3].bv = round_q(pipe_reg[2].prod_bv);
        pipe_next[3].gd = round_q(pipe_reg[2].prod_gd);

        // Stage 4: 0.04*V^2, b*V - u
        pipe_next[4]          = pipe_reg[3];
        pipe_next[4].prod_004 = Q_004 * pipe_reg[3].sq;
        pipe_next[4].diff     = sat_wide(wide(pipe_reg[3].bv) - wide(pipe_reg[3].u));

        // Stage 5: round 0.04*V^2, start rate*(b*V - u)
        pipe_next[5]         = pipe_reg[4];
        pipe_next[5].a004    = round_q(pipe_reg[4].prod_004);
        pipe_next[5].prod_rd = recovery_rate_reg * pipe_reg[4].diff;

        // Stage 6: t = 0.04*V^2 + 5V + 140 - u, round rate*(b*V - u)
        pipe_next[6]    = pipe_reg[5];
        pipe_next[6].t  = sat_wide(wide(pipe_reg[5].a004) + (wide(pipe_reg[5].v) <<< 2)
                                   + wide(pipe_reg[5].v) + Q_140 - wide(pipe_reg[5].u));
        pipe_next[6].ur = round_q(pipe_reg[5].prod_rd);

        // Stage 7: step_scale*t, new recovery
        pipe_next[7]         = pipe_reg[6];
        pipe_next[7].prod_st = step_scale_reg * pipe_reg[6].t;
        pipe_next[7].u_new   = sat_wide(wide(pipe_reg[6].u) + wide(pipe_reg[6].ur));

        // Stage 8: round step_scale*t
        pipe_next[8]    = pipe_reg[7];
        pipe_next[8].st = round_q(pipe_reg[7].prod_st);

        // Stage 9: V + step_scale*t
        pipe_next[9]    = pipe_reg[8];
        pipe_next[9].vb = sat_wide(wide(pipe_reg[8].v) + wide(pipe_reg[8].st));
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k <= NSTG; k++) begin
            pipe_reg[k] <= pipe_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[NSTG-1:1], accept};
        end
    end

    // Write-back: add the drive term and select the case
    always_comb begin
        v_step = sat_wide(wide(pipe_reg[NSTG].vb) + wide(pipe_reg[NSTG].gd));
        wb     = '{v: pipe_reg[NSTG].v, u: pipe_reg[NSTG].u, cnt: pipe_reg[NSTG].cnt};
        unique case (pipe_reg[NSTG].mode)
            MODE_SKIP: begin
                wb = '{v: pipe_reg[NSTG].v, u: pipe_reg[NSTG].u, cnt: pipe_reg[NSTG].cnt};
            end
            MODE_REFR: begin
                wb.cnt = pipe_reg[NSTG].cnt - CNT_W'(1);
            end
            MODE_FIRE: begin
                wb.v   = reset_potential_reg;
                wb.u   = pipe_reg[NSTG].u_fire;
                wb.cnt = refract_steps_reg;
            end
            MODE_STEP: begin
                wb.v = v_step;
                wb.u = pipe_reg[NSTG].u_new;
            end
        endcase

        res.idx       = pipe_reg[NSTG].idx;
        res.fired     = (pipe_reg[NSTG].mode == MODE_FIRE);
        res.potential = (pipe_reg[NSTG].mode == MODE_SKIP) ? '0 : wb.v;
    end

    assign mem_we    = clearing_reg || (valid_reg[NSTG] && (pipe_reg[NSTG].mode != MODE_SKIP));
    assign mem_waddr = clearing_reg ? clr_addr_reg : AW'(pipe_reg[NSTG].idx);
    assign mem_wdata = clearing_reg ? nstate_t'('0) : wb;

    // ------------------------------------------------------------------
    // Output queue; credits count requests in flight plus queued results
    // ------------------------------------------------------------------
    result_t        fifo_mem [FIFO_DEPTH];
    logic [FAW-1:0] wr_ptr_reg;
    logic [FAW-1:0] rd_ptr_reg;
    logic [FAW:0]   fifo_cnt_reg;
    logic           push;
    result_t        head;

    assign push    = valid_reg[NSTG];
    assign deliver = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            credit_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (deliver) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_reg + (FAW + 1)'(push) - (FAW + 1)'(deliver);
            credit_reg   <= credit_reg + (FAW + 1)'(accept) - (FAW + 1)'(deliver);
        end
    end

    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = M_TDATA_W'({head.potential, head.idx});
    assign m_tuser  = head.fired;

endmodule

`default_nettype wire

// File: sv/izn_port_checker.sv
// Port-level checks of the Izhikevich neuron update core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module izn_port_checker #(
    parameter int NEURONS = 1024
) (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [izn_pkg::S_TDATA_W-1:0]    s_tdata,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [izn_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic [izn_pkg::M_TUSER_W-1:0]    m_tuser
);
    import izn_pkg::*;

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset starts the clearing pass: no request taken, no result shown
    assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("core not idle after reset");

    // Neurons beyond the memory neither fire nor report a potential
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (32'(m_tdata[IDX_W-1:0]) >= 32'(NEURONS))
        |-> !m_tuser[0] && (m_tdata[IDX_W +: Q_W] == '0))
        else $error("out-of-range neuron produced a result");

    // The same neuron is never taken on two consecutive cycles
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready
        |=> !(s_tvalid && s_tready && (s_tdata[IDX_W-1:0] == $past(s_tdata[IDX_W-1:0]))))
        else $error("request for a neuron still in flight was taken");

endmodule

bind izhikevich_neuron_update_core izn_port_checker #(
    .NEURONS (NEURONS)
) u_izn_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: tb/sv/izhikevich_neuron_update_core_tb.sv
// Self-checking testbench of the Izhikevich neuron update core: directed table, then random phases.
`timescale 1ns / 1ps

module izhikevich_neuron_update_core_tb;

    import izn_pkg::*;

    localparam int    NEURONS      = 1024;
    localparam int    FRAC_BITS    = 16;
    localparam int    PHASES       = 8;
    localparam int    PHASE_ITEMS  = 225;
    localparam int    MAX_GAP      = 14;
    localparam int    HOLD_CYCLES  = 400;     // long result-side hold to fill the output queue
    localparam int    SETTLE       = 16;      // idle margin after the last result, past the pipeline
    localparam int    LIMIT_CYCLES = 500000;
    localparam int    DIRECTED     = 34;

    // fixed-point constants of the Euler step
    localparam longint Q_HALF = longint'(1) << (FRAC_BITS - 1);
    localparam longint Q_004  = ((longint'(4) << FRAC_BITS) + 50) / 100;
    localparam longint Q_140  = longint'(140) << FRAC_BITS;
    localparam longint Q_MAX  = 64'sd2147483647;
    localparam longint Q_MIN  = -64'sd2147483648;

    typedef enum logic [1:0] {ROW_WRITE, ROW_FIXED, ROW_PREDICT} row_kind_t;
    typedef enum logic [1:0] {SET_PLAUSIBLE, SET_ANY, SET_FLOOR, SET_CEILING} setting_t;

    // one line of the directed table: a register write, or a request whose result is
    // either typed in (ROW_FIXED) or taken from the predictor (ROW_PREDICT)
    typedef struct {
        row_kind_t        kind;
        cfg_index_t       addr;
        logic [IDX_W-1:0] neuron;
        q_t               value;      // drive current, or register data
        logic             fired;
        q_t               potential;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // neuron_index, drive_current
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // neuron_out, potential
    logic [M_TUSER_W-1:0] m_tuser;    // fired

    // shadow of the register file and of the neuron memory
    q_t               reg_shadow    [8];
    q_t               potential_mem [NEURONS];
    q_t               recovery_mem  [NEURONS];
    logic [CNT_W-1:0] countdown_mem [NEURONS];

    result_t pending_results [$];
    int      mismatch_count;
    int      cycle_count;
    bit      quiet_sides;    // no random gaps on either side while set
    bit      hold_pending;   // ask the result side for one long hold

    stim_row_t directed_rows [DIRECTED] = '{
        // reset defaults: both gains are zero, so the potential stays at zero
        '{ROW_FIXED,   CFG_REFRACT_STEPS,  10'd0,    32'sh7FFFFFFF,   1'b0, 32'sd0},
        '{ROW_FIXED,   CFG_REFRACT_STEPS,  10'd1023, 32'sh80000000,   1'b0, 32'sd0},
        '{ROW_WRITE,   CFG_INPUT_GAIN,     10'd0,    32'sd65536,      1'b0, 32'sd0},
        '{ROW_WRITE,   CFG_REFRACT_STEPS,  10'd0,    32'sd2,          1'b0, 32'sd0},
        // unit gain: drive of 40 mV lands directly, then the neuron fires and rests twice
        '{ROW_FIXED,   CFG_REFRACT_STEPS,  10'd5,    32'sd2621440,    1'b0, 32'sd2621440},
        '{ROW_FIXED,   CFG_REFRACT_STEPS,  10'd5,    32'sd0,          1'b1, -32'sd4259840},
        '{ROW_FIXED,   CFG_REFRACT_STEPS,  10'd5,    32'sd2621440,    1'b0, -32'sd4259840},
        '{ROW_FIXED,   CFG_REFRACT_STEPS,  10'd5,    32'sd2621440,    1'b0, -32'sd4259840},
        '{ROW_FIXED,   CFG_REFRACT_STEPS,  10'd5,    32'sd0,          1'b0, -32'sd4259840},
        // potential exactly at threshold fires
        '{ROW_FIXED,   CFG_REFRACT_STEPS,  10'd6,    32'sd1966080,    1'b0, 32'sd1966080},
        '{ROW_FIXED,   CFG_REFRACT_STEPS,  10'd6,    32'sd0,          1'b1, -32'sd4259840},
        // extremes of the drive pass straight through unit gain
        '{ROW_FIXED,   CFG_REFRACT_STEPS,  10'd7,    32'sh7FFFFFFF,   1'b0, 32'sh7FFFFFFF},
        '{ROW_FIXED,   CFG_REFRACT_STEPS,  10'd8,    32'sh80000000,   1'b0, 32'sh80000000},
        '{ROW_FIXED,   CFG_REFRACT_STEPS,  10'd7,    32'sd0,          1'b1, -32'sd4259840},
        '{ROW_WRITE,   CFG_FIRE_THRESHOLD, 10'd0,    32'sd1966080,    1'b0, 32'sd0},
        '{ROW_WRITE,   CFG_RECOVERY_RATE,  10'd0,    32'sd655,        1'b0, 32'sd0},
        '{ROW_WRITE,   CFG_RECOVERY_SENS,  10'd0,    32'sd16384,      1'b0, 32'sd0},
        '{ROW_WRITE,   CFG_RESET_POT,      10'd0,    -32'sd3276800,   1'b0, 32'sd0},
        '{ROW_WRITE,   CFG_RECOVERY_JUMP,  10'd0,    32'sd131072,     1'b0, 32'sd0},
        '{ROW_WRITE,   CFG_STEP_SCALE,     10'd0,    32'sd32768,      1'b0, 32'sd0},
        '{ROW_WRITE,   CFG_REFRACT_STEPS,  10'd0,    32'sd0,          1'b0, 32'sd0},
        // full Euler steps: saturating square, repeated drive on one neuron back to back
        '{ROW_PREDICT, CFG_REFRACT_STEPS,  10'd8,    32'sd0,          1'b0, 32'sd0},
        '{ROW_PREDICT, CFG_REFRACT_STEPS,  10'd8,    32'sd0,          1'b0, 32'sd0},
        '{ROW_PREDICT, CFG_REFRACT_STEPS,  10'd9,    32'sd655360,     1'b0, 32'sd0},
        '{ROW_PREDICT, CFG_REFRACT_STEPS,  10'd9,    32'sd655360,     1'b0, 32'sd0},
        '{ROW_PREDICT, CFG_REFRACT_STEPS,  10'd9,    32'sd655360,     1'b0, 32'sd0},
        '{ROW_PREDICT, CFG_REFRACT_STEPS,  10'd9,    32'sd655360,     1'b0, 32'sd0},
        '{ROW_PREDICT, CFG_REFRACT_STEPS,  10'd6,    -32'sd196608,    1'b0, 32'sd0},
        '{ROW_PREDICT, CFG_REFRACT_STEPS,  10'd1023, 32'sd327680,     1'b0, 32'sd0},
        '{ROW_PREDICT, CFG_REFRACT_STEPS,  10'd0,    32'sh7FFFFFFF,   1'b0, 32'sd0},
        '{ROW_WRITE,   CFG_REFRACT_STEPS,  10'd0,    32'sd1023,       1'b0, 32'sd0},
        // longest refractory countdown
        '{ROW_PREDICT, CFG_REFRACT_STEPS,  10'd9,    32'sh7FFFFFFF,   1'b0, 32'sd0},
        '{ROW_PREDICT, CFG_REFRACT_STEPS,  10'd9,    32'sd0,          1'b0, 32'sd0},
        '{ROW_PREDICT, CFG_REFRACT_STEPS,  10'd9,    32'sd0,          1'b0, 32'sd0}
    };

    izhikevich_neuron_update_core #(
        .NEURONS   (NEURONS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Give up if the run hangs: something expected never came back.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("** izhikevich_neuron_update_core: FAILED **");
        $finish;
    end

    function automatic q_t clamp_q(input longint x);
        if (x > Q_MAX) return q_t'(Q_MAX);
        if (x < Q_MIN) return q_t'(Q_MIN);
        return q_t'(x);
    endfunction

    // exact product, add one half, floor to FRAC_BITS, saturate
    function automatic q_t fix_mul(input longint a, input longint b);
        longint p;
        p = a * b + Q_HALF;
        return clamp_q(p >>> FRAC_BITS);
    endfunction

    // Advance the shadow neuron by one step and return the result it must produce.
    function automatic result_t advance_neuron(input logic [IDX_W-1:0] n, input q_t drive);
        result_t r;
        q_t      v;
        q_t      u;
        q_t      sq;
        q_t      t;
        q_t      vb;
        q_t      diff;
        v       = potential_mem[n];
        u       = recovery_mem[n];
        r.idx   = n;
        r.fired = 1'b0;
        if (countdown_mem[n] != '0) begin
            // resting: count down, leave potential and recovery alone
            countdown_mem[n] = countdown_mem[n] - 1'b1;
        end else if (v >= reg_shadow[CFG_FIRE_THRESHOLD]) begin
            r.fired          = 1'b1;
            countdown_mem[n] = reg_shadow[CFG_REFRACT_STEPS][CNT_W-1:0];
            v                = reg_shadow[CFG_RESET_POT];
            u                = clamp_q(longint'(u) + longint'(reg_shadow[CFG_RECOVERY_JUMP]));
        end else begin
            sq   = fix_mul(v, v);
            t    = clamp_q(longint'(fix_mul(Q_004, sq)) + 5 * longint'(v) + Q_140
                           - longint'(u));
            vb   = clamp_q(longint'(v) + longint'(fix_mul(reg_shadow[CFG_STEP_SCALE], t)));
            diff = clamp_q(longint'(fix_mul(reg_shadow[CFG_RECOVERY_SENS], v)) - longint'(u));
            u    = clamp_q(longint'(u)
                           + longint'(fix_mul(reg_shadow[CFG_RECOVERY_RATE], diff)));
            v    = clamp_q(longint'(vb) + longint'(fix_mul(reg_shadow[CFG_INPUT_GAIN], drive)));
        end
        potential_mem[n] = v;
        recovery_mem[n]  = u;
        r.potential      = v;
        return r;
    endfunction

    // Drop the request line and wait until every result is back and the pipeline is empty.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write one register; the caller lowers the write enable after a batch.
    task automatic write_reg(input cfg_index_t addr, input q_t data);
        cfg_wr_en        <= 1'b1;
        cfg_index        <= addr;
        cfg_wdata        <= data;
        reg_shadow[addr]  = data;
        @(posedge aclk);
    endtask

    // Offer one request after a random gap, hold it until taken, then record its result.
    task automatic send_request(input logic [IDX_W-1:0] n, input q_t drive,
                                input bit use_typed, input result_t typed_result);
        int unsigned gap;
        result_t     predicted;
        gap = quiet_sides ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - IDX_W - Q_W){1'b0}}, drive, n};
        do @(posedge aclk); while (!s_tready);
        predicted = advance_neuron(n, drive);
        pending_results.push_back(use_typed ? typed_result : predicted);
    endtask

    // Set up a whole register file for one random phase, extremes included.
    task automatic program_phase(input setting_t setting);
        q_t values [8];
        wait_idle();
        case (setting)
            SET_PLAUSIBLE: begin
                values[CFG_REFRACT_STEPS]  = q_t'($urandom_range(0, 6));
                values[CFG_FIRE_THRESHOLD] = q_t'($urandom_range(25, 35) * 65536);
                values[CFG_RECOVERY_RATE]  = q_t'($urandom_range(100, 2000));
                values[CFG_RECOVERY_SENS]  = q_t'($urandom_range(13107, 16384));
                values[CFG_RESET_POT]      = -q_t'($urandom_range(50, 65) * 65536);
                values[CFG_RECOVERY_JUMP]  = q_t'($urandom_range(2, 8) * 65536);
                values[CFG_STEP_SCALE]     = q_t'($urandom_range(6554, 32768));
                values[CFG_INPUT_GAIN]     = q_t'($urandom_range(16384, 65536));
            end
            SET_ANY: begin
                foreach (values[k]) values[k] = q_t'($urandom());
                values[CFG_REFRACT_STEPS] = q_t'($urandom_range(0, 1023));
            end
            SET_FLOOR: begin
                foreach (values[k]) values[k] = 32'sh80000000;
                values[CFG_REFRACT_STEPS] = 32'sd0;
            end
            default: begin
                foreach (values[k]) values[k] = 32'sh7FFFFFFF;
                values[CFG_REFRACT_STEPS] = 32'sd1023;
            end
        endcase
        for (int k = 0; k < 8; k++) write_reg(cfg_index_t'(k), values[k]);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: random stalls, the odd long hold, then check against the oldest expectation.
    initial begin : result_sink
        int unsigned stall;
        result_t     want;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_pending) begin
                stall        = HOLD_CYCLES;
                hold_pending = 1'b0;
            end else begin
                stall = quiet_sides ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: neuron %0d fired %0b potential %0d",
                         $time, m_tdata[IDX_W-1:0], m_tuser[0],
                         $signed(m_tdata[IDX_W+Q_W-1:IDX_W]));
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[IDX_W-1:0] !== want.idx) begin
                    $display("%0t: neuron_out expected %0d, got %0d",
                             $time, want.idx, m_tdata[IDX_W-1:0]);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.fired) begin
                    $display("%0t: fired (neuron %0d) expected %0b, got %0b",
                             $time, want.idx, want.fired, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tdata[IDX_W+Q_W-1:IDX_W] !== want.potential) begin
                    $display("%0t: potential (neuron %0d) expected %0d, got %0d",
                             $time, want.idx, want.potential,
                             $signed(m_tdata[IDX_W+Q_W-1:IDX_W]));
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain, verdict.
    initial begin : stimulus
        result_t     typed;
        bit          writing;
        setting_t    setting;
        logic [IDX_W-1:0] n;
        q_t          drive;
        int unsigned pick;

        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        mismatch_count = 0;
        quiet_sides    = 1'b0;
        hold_pending   = 1'b0;
        writing        = 1'b0;

        // register reset values
        reg_shadow[CFG_REFRACT_STEPS]  = 32'sd0;
        reg_shadow[CFG_FIRE_THRESHOLD] = 32'sd1966080;
        reg_shadow[CFG_RECOVERY_RATE]  = 32'sd0;
        reg_shadow[CFG_RECOVERY_SENS]  = 32'sd13107;
        reg_shadow[CFG_RESET_POT]      = -32'sd4259840;
        reg_shadow[CFG_RECOVERY_JUMP]  = 32'sd524288;
        reg_shadow[CFG_STEP_SCALE]     = 32'sd0;
        reg_shadow[CFG_INPUT_GAIN]     = 32'sd0;
        foreach (potential_mem[k]) begin
            potential_mem[k] = '0;
            recovery_mem[k]  = '0;
            countdown_mem[k] = '0;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table; a run of writes goes in as one batch while idle.
        for (int row = 0; row < DIRECTED; row++) begin
            if (directed_rows[row].kind == ROW_WRITE) begin
                if (!writing) wait_idle();
                writing = 1'b1;
                write_reg(directed_rows[row].addr, directed_rows[row].value);
                if (row + 1 == DIRECTED || directed_rows[row + 1].kind != ROW_WRITE) begin
                    cfg_wr_en <= 1'b0;
                    writing = 1'b0;
                end
            end else begin
                typed.idx       = directed_rows[row].neuron;
                typed.fired     = directed_rows[row].fired;
                typed.potential = directed_rows[row].potential;
                send_request(directed_rows[row].neuron, directed_rows[row].value,
                             directed_rows[row].kind == ROW_FIXED, typed);
            end
        end

        // Random phases. Most requests go to a small pool of neurons so that each of them
        // runs through many steps, fires and rests; the rest hit the top 16 or the whole memory.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1, 6:    setting = SET_ANY;
                3:       setting = SET_CEILING;
                5:       setting = SET_FLOOR;
                default: setting = SET_PLAUSIBLE;
            endcase
            program_phase(setting);
            quiet_sides = (phase == 2 || phase == 4 || phase == 6);
            // hold the result side while requests keep coming, so the input backs up
            if (phase == 4) hold_pending = 1'b1;
            for (int item = 0; item < PHASE_ITEMS; item++) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)      n = IDX_W'($urandom_range(0, 15));
                else if (pick < 7) n = IDX_W'($urandom_range(NEURONS - 16, NEURONS - 1));
                else               n = IDX_W'($urandom_range(0, NEURONS - 1));
                if (setting == SET_PLAUSIBLE && $urandom_range(0, 7) != 0)
                    drive = q_t'($urandom_range(0, 30 * 65536)) - q_t'(8 * 65536);
                else
                    drive = q_t'($urandom());
                send_request(n, drive, 1'b0, typed);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // catch anything extra that trails the last expected result
        repeat (SETTLE * 2) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("** izhikevich_neuron_update_core: PASSED **");
        end else begin
            $display("** izhikevich_neuron_update_core: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/izn_pkg.sv
sv/izhikevich_neuron_update_core.sv
sv/izn_port_checker.sv
tb/sv/izhikevich_neuron_update_core_tb.sv
